// ===== design/priority_scheduler_with_aging_unit_defines.svh =====
// ----------------------------------------------------------------------------
// priority scheduler assertion macros
// shared concurrent assertion forms, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULER_WITH_AGING_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// shared widths, register codes and inter-module structs of the scheduler
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int IDX_W     = 2;   // width of a slot index that can win
	localparam int MASK_BITS = 4;   // slots with a ready bit
	localparam int DP_W      = 7;   // dynamic priority width
	localparam int PRIO_W    = 4;   // configured priority width
	localparam int TC_W      = 3;   // task count width
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_W     = 2;

	localparam logic [DP_W-1:0]   DP_MAX     = 7'd127;
	localparam logic [PRIO_W-1:0] PRIO_RESET = 4'd1;
	localparam logic [TC_W-1:0]   TC_RESET   = 3'd1;

	// register index codes
	localparam logic [REG_W-1:0] REG_TASK_COUNT = 2'd0;
	localparam logic [REG_W-1:0] REG_PRIO_1     = 2'd1;
	localparam logic [REG_W-1:0] REG_PRIO_2     = 2'd2;
	localparam logic [REG_W-1:0] REG_PRIO_3     = 2'd3;

	// running best handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [DP_W-1:0]   prio;
	} tok_t;

	// per-transaction scan context
	typedef struct packed {
		logic [MASK_BITS-1:0] mask;
		logic [TC_W-1:0]      tc;
	} scan_ctl_t;

	// priority register write toward the cells
	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  slot;
		logic [PRIO_W-1:0] val;
	} cfg_wr_t;

	// slot-addressed command (aging or reload)
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} slot_cmd_t;

endpackage

// ===== design/psa_cell.sv =====
// ----------------------------------------------------------------------------
// psa_cell
// one task slot: holds its priorities and yield count, compares against the
// running best passing through and forwards the result to the next cell
// ----------------------------------------------------------------------------
module psa_cell
	import psa_pkg::*;
#(
	parameter int IDX         = 1,
	parameter int YIELD_LIMIT = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scan_ctl_t         ctl,
	input  cfg_wr_t           cfg,
	input  slot_cmd_t         reload,
	input  slot_cmd_t         age_in,
	input  tok_t              tok_in,
	output tok_t              tok_out,
	output slot_cmd_t         age_out,
	output logic [PRIO_W-1:0] base
);

	localparam bit               IN_MASK = (IDX < MASK_BITS);
	localparam logic [IDX_W-1:0] IDX_V   = IDX_W'(IDX);
	localparam logic [TC_W-1:0]  IDX_TC  = TC_W'(IDX);
	localparam int               YC_W    = $clog2(YIELD_LIMIT + 1);
	localparam logic [YC_W-1:0]  YC_LIM  = YC_W'(YIELD_LIMIT);

	logic [PRIO_W-1:0] base_q;
	logic [DP_W-1:0]   dp_q;
	logic [YC_W-1:0]   yc_q;
	tok_t              tok_q;
	logic              eligible;
	logic              win;
	logic              hit_cfg;
	logic              hit_reload;
	logic              hit_age;

	assign eligible = IN_MASK && ctl.mask[IDX_V] && (IDX_TC < ctl.tc);
	assign win      = tok_in.valid && eligible && (dp_q > tok_in.prio);

	// displaced best other than idle gets aged
	assign age_out.en  = win && (tok_in.idx != '0);
	assign age_out.idx = tok_in.idx;

	assign hit_cfg    = IN_MASK && cfg.wr && (cfg.slot == IDX_V);
	assign hit_reload = IN_MASK && reload.en && (reload.idx == IDX_V);
	assign hit_age    = IN_MASK && age_in.en && (age_in.idx == IDX_V);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			if (win) begin
				tok_q.idx  <= IDX_V;
				tok_q.prio <= dp_q;
			end else begin
				tok_q.idx  <= tok_in.idx;
				tok_q.prio <= tok_in.prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= PRIO_RESET;
			dp_q   <= '0;
			yc_q   <= '0;
		end else if (hit_cfg) begin
			base_q <= cfg.val;
			dp_q   <= DP_W'(cfg.val);
			yc_q   <= '0;
		end else if (hit_reload) begin
			dp_q <= DP_W'(base_q);
			yc_q <= '0;
		end else if (hit_age) begin
			if (yc_q == YC_LIM) begin
				yc_q <= '0;
				if (dp_q != DP_MAX) begin
					dp_q <= dp_q + 1'b1;
				end
			end else begin
				yc_q <= yc_q + 1'b1;
			end
		end
	end

	assign tok_out = tok_q;
	assign base    = base_q;

endmodule

// ===== design/priority_scheduler_with_aging_unit.sv =====
// an accepted request seeds start_q, the running best walks the row of slot cells
// one cell per cycle, then waits in fin_valid_q and moves to out_valid_q (grant_valid)
// a new request is taken only once the winner of the last has left fin_valid_q
// a finished grant waits in the output register while the next request is taken
// reset: arst_n clears the busy and valid flags, dynamic priorities and yield counts to zero,
// task_count to 1 and every configured slot priority to 1
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_unit
// tick-driven task scheduler with priority aging over a chain of slot cells
// ----------------------------------------------------------------------------
`include "priority_scheduler_with_aging_unit_defines.svh"

module priority_scheduler_with_aging_unit
	import psa_pkg::*;
#(
	parameter int SLOT_COUNT  = 4,
	parameter int YIELD_LIMIT = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel: one scheduling tick
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [MASK_BITS-1:0] ready_mask,
	// grant channel
	output logic                 grant_valid,
	input  logic                 grant_ready,
	output logic [IDX_W-1:0]     chosen_slot,
	// apb configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	// ---------------------------------------------------------------- control
	logic                 busy_q;        // transaction in flight, scan or grant pending
	logic [MASK_BITS-1:0] mask_q;        // ready mask of the transaction in flight
	logic [TC_W-1:0]      tc_q;          // task_count register
	tok_t                 start_q;       // seed token: idle slot as the running best
	logic                 fin_valid_q;   // scan finished, winner waiting for the output
	logic [IDX_W-1:0]     fin_idx_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     chosen_q;
	logic                 accept;
	logic                 deliver;

	// chain wiring: tok_w[k] enters cell k+1, tok_w[0] is the seed
	tok_t                 tok_w   [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] tok_vld;
	slot_cmd_t            age_v   [1:SLOT_COUNT-1];
	logic [PRIO_W-1:0]    base_w  [1:SLOT_COUNT-1];
	logic [PRIO_W-1:0]    prio_rd [1:3];
	slot_cmd_t            age;
	slot_cmd_t            reload;
	scan_ctl_t            ctl;
	cfg_wr_t              cfg;
	logic                 apb_wr;
	logic [REG_W-1:0]     reg_idx;

	assign req_ready = !busy_q;
	assign accept    = req_valid && req_ready;

	// winner moves to the output register once it is free or being emptied
	assign deliver = fin_valid_q && (!out_valid_q || grant_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (deliver) begin
			busy_q <= 1'b0;
		end
	end

	// mask is held for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= ready_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else begin
			start_q.valid <= accept;
			start_q.idx   <= '0;
			start_q.prio  <= '0;
		end
	end

	// ------------------------------------------------------------ slot chain
	assign tok_w[0] = start_q;
	assign ctl.mask = mask_q;
	assign ctl.tc   = tc_q;

	for (genvar k = 1; k < SLOT_COUNT; k++) begin : g_cell
		psa_cell #(
			.IDX         (k),
			.YIELD_LIMIT (YIELD_LIMIT)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.cfg     (cfg),
			.reload  (reload),
			.age_in  (age),
			.tok_in  (tok_w[k-1]),
			.tok_out (tok_w[k]),
			.age_out (age_v[k]),
			.base    (base_w[k])
		);
	end

	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_vld
		assign tok_vld[k] = tok_w[k].valid;
	end

	// only the cell holding the token can raise an aging request
	always_comb begin
		age = '0;
		for (int k = 1; k < SLOT_COUNT; k++) begin
			if (age_v[k].en) begin
				age = age_v[k];
			end
		end
	end

	// granted slot falls back to its configured priority
	assign reload.en  = deliver;
	assign reload.idx = fin_idx_q;

	// ---------------------------------------------------------- grant output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= 1'b0;
		end else if (tok_w[SLOT_COUNT-1].valid) begin
			fin_valid_q <= 1'b1;
		end else if (deliver) begin
			fin_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_w[SLOT_COUNT-1].valid) begin
			fin_idx_q <= tok_w[SLOT_COUNT-1].idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (grant_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) begin
			chosen_q <= fin_idx_q;
		end
	end

	assign grant_valid = out_valid_q;
	assign chosen_slot = chosen_q;

	// ------------------------------------------------------- register access
	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= TC_RESET;
		end else if (apb_wr && (reg_idx == REG_TASK_COUNT)) begin
			tc_q <= pwdata[TC_W-1:0];
		end
	end

	// a zero priority would not rank above idle, so it is dropped
	assign cfg.wr   = apb_wr && (reg_idx != REG_TASK_COUNT) && (pwdata[PRIO_W-1:0] != '0);
	assign cfg.slot = reg_idx;
	assign cfg.val  = pwdata[PRIO_W-1:0];

	// absent slots read back their reset priority
	for (genvar r = 1; r <= 3; r++) begin : g_rd
		if (r < SLOT_COUNT) begin : g_present
			assign prio_rd[r] = base_w[r];
		end else begin : g_absent
			assign prio_rd[r] = PRIO_RESET;
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TASK_COUNT: prdata = DATA_W'(tc_q);
			REG_PRIO_1:     prdata = DATA_W'(prio_rd[1]);
			REG_PRIO_2:     prdata = DATA_W'(prio_rd[2]);
			REG_PRIO_3:     prdata = DATA_W'(prio_rd[3]);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------ assertions
	`PSA_ASSERT_NOW(a_single_token, 1'b1, $onehot0(tok_vld), "more than one token in the chain")
	`PSA_ASSERT_NOW(a_fin_alone, fin_valid_q, tok_vld == '0, "token in chain while winner waits")
	`PSA_ASSERT_NOW(a_idle_clean, !busy_q, !fin_valid_q && (tok_vld == '0), "scan state while idle")
	`PSA_ASSERT_NEXT(a_accept_busy, accept, busy_q && start_q.valid, "accepted tick did not start")

endmodule
